[rtl/elevator_target_scheduler_assert.svh]
// Assertion macros shared by the elevator target scheduler checkers.
`ifndef ELEVATOR_TARGET_SCHEDULER_ASSERT_SVH
`define ELEVATOR_TARGET_SCHEDULER_ASSERT_SVH

// Antecedent holds, so the consequent must hold at the same edge.
`define ETS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent holds, so the consequent must hold at the next edge.
`define ETS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ets_pkg.sv]
// Package with the shared constants and types of the elevator target scheduler.
`default_nettype none

package ets_pkg;

    localparam int FLOORS  = 16;
    localparam int FLOOR_W = 5;
    localparam int IDX_W   = $clog2(FLOORS);

    localparam logic [1:0] KIND_PRESS  = 2'd0;
    localparam logic [1:0] KIND_RESCAN = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_NEW   = 2'd1;
    localparam logic [1:0] EV_MOVED = 2'd2;
    localparam logic [1:0] EV_STOP  = 2'd3;

    localparam logic [1:0] HEAD_STOP = 2'd0;
    localparam logic [1:0] HEAD_UP   = 2'd1;
    localparam logic [1:0] HEAD_DOWN = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic commit;
    } t_dp_cmd;

endpackage

`default_nettype wire

[rtl/elevator_target_scheduler.sv]
// Top level of the elevator target scheduler: controller plus datapath.
//
//  Channel   Direction   Handshake                   Beat content
//  input     in          i_in_valid / o_in_stall     i_kind, i_floor
//  output    out         o_out_valid / i_out_stall   o_event_res, o_cabin_floor,
//                                                    o_target_floor, o_heading
//
// Every input beat passes through the idle and the execute state: on accept
// the pressed floor is marked in the pending bitmap, and in the execute state
// the bitmap scan or the tick update is applied and the result beat is loaded.
// The execute state waits only while an earlier result beat is still stalled.
// A new input beat is accepted while a finished result waits to be taken.
// Reset is synchronous and active low; it empties the bitmap, puts the cabin
// and the goal on floor 1 with no heading, and drops the output valid.
`default_nettype none

module elevator_target_scheduler (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_kind,
    input  wire logic [ets_pkg::FLOOR_W-1:0]   i_floor,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [1:0]                         o_event_res,
    output logic [ets_pkg::FLOOR_W-1:0]        o_cabin_floor,
    output logic [ets_pkg::FLOOR_W-1:0]        o_target_floor,
    output logic [1:0]                         o_heading
);
    import ets_pkg::*;

    // Commands from the controller to the datapath: load marks the press
    // and captures the beat kind, commit applies the scan or the tick.
    t_dp_cmd cmd;

    ets_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // The cabin, goal and heading outputs come straight from the state
    // registers; they only change at a commit, which waits until the
    // previous result beat has been taken, so a stalled beat holds.
    ets_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_kind         (i_kind),
        .i_floor        (i_floor),
        .o_event_res    (o_event_res),
        .o_cabin_floor  (o_cabin_floor),
        .o_target_floor (o_target_floor),
        .o_heading      (o_heading)
    );

endmodule

`default_nettype wire

[rtl/ets_ctrl.sv]
// Controller state machine of the elevator target scheduler.
`default_nettype none

module ets_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output ets_pkg::t_dp_cmd     o_cmd
);
    import ets_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.commit = out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[rtl/ets_datapath.sv]
// Datapath of the elevator target scheduler: floor bitmap, cabin state and scan.
`default_nettype none

module ets_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ets_pkg::t_dp_cmd              i_cmd,
    input  wire logic [1:0]                    i_kind,
    input  wire logic [ets_pkg::FLOOR_W-1:0]   i_floor,
    output logic [1:0]                         o_event_res,
    output logic [ets_pkg::FLOOR_W-1:0]        o_cabin_floor,
    output logic [ets_pkg::FLOOR_W-1:0]        o_target_floor,
    output logic [1:0]                         o_heading
);
    import ets_pkg::*;

    logic [FLOORS-1:0]  r_pending;
    logic [FLOORS-1:0]  n_pending;
    logic [FLOOR_W-1:0] r_cabin;
    logic [FLOOR_W-1:0] n_cabin;
    logic [FLOOR_W-1:0] r_goal;
    logic [FLOOR_W-1:0] n_goal;
    logic [1:0]         r_heading;
    logic [1:0]         n_heading;
    logic [1:0]         r_kind;
    logic [1:0]         r_event;
    logic [1:0]         n_event;

    logic               press_ok;
    logic [IDX_W-1:0]   press_idx;
    logic [IDX_W-1:0]   cab_idx;
    logic [IDX_W-1:0]   goal_idx;
    logic               up_hit;
    logic [IDX_W-1:0]   up_idx;
    logic               dn_hit;
    logic [IDX_W-1:0]   dn_idx;
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic [FLOOR_W-1:0] hit_floor;

    assign press_ok  = (i_kind == KIND_PRESS) && (i_floor != '0)
                       && (32'(i_floor) <= FLOORS);
    assign press_idx = IDX_W'(i_floor - FLOOR_W'(1));
    assign cab_idx   = IDX_W'(r_cabin - FLOOR_W'(1));
    assign goal_idx  = IDX_W'(r_goal - FLOOR_W'(1));

    // Nearest pending floor at or above the cabin, and at or below it.
    always_comb begin
        up_hit = 1'b0;
        up_idx = '0;
        for (int i = FLOORS - 1; i >= 0; i--) begin
            if (r_pending[i] && (IDX_W'(i) >= cab_idx)) begin
                up_hit = 1'b1;
                up_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        dn_hit = 1'b0;
        dn_idx = '0;
        for (int i = 0; i < FLOORS; i++) begin
            if (r_pending[i] && (IDX_W'(i) <= cab_idx)) begin
                dn_hit = 1'b1;
                dn_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        if (r_heading == HEAD_UP) begin
            hit     = up_hit || dn_hit;
            hit_idx = up_hit ? up_idx : dn_idx;
        end else begin
            hit     = dn_hit || up_hit;
            hit_idx = dn_hit ? dn_idx : up_idx;
        end
    end

    assign hit_floor = FLOOR_W'(hit_idx) + FLOOR_W'(1);

    always_comb begin
        n_pending = r_pending;
        n_cabin   = r_cabin;
        n_goal    = r_goal;
        n_heading = r_heading;
        n_event   = r_event;
        if (i_cmd.load) begin
            if (press_ok) begin
                n_pending[press_idx] = 1'b1;
            end
        end else if (i_cmd.commit) begin
            n_event = EV_NONE;
            unique case (r_kind)
                KIND_PRESS, KIND_RESCAN: begin
                    if (hit) begin
                        n_goal    = hit_floor;
                        n_heading = (hit_floor > r_cabin) ? HEAD_UP : HEAD_DOWN;
                        n_event   = EV_NEW;
                    end
                end
                KIND_TICK: begin
                    if (r_goal == r_cabin) begin
                        n_pending[goal_idx] = 1'b0;
                        n_event = EV_STOP;
                    end else begin
                        if ((r_heading == HEAD_UP) && (32'(r_cabin) < FLOORS)) begin
                            n_cabin = r_cabin + FLOOR_W'(1);
                        end else if ((r_heading == HEAD_DOWN) && (r_cabin > FLOOR_W'(1))) begin
                            n_cabin = r_cabin - FLOOR_W'(1);
                        end
                        n_event = EV_MOVED;
                    end
                end
                default: n_event = EV_NONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_cabin   <= FLOOR_W'(1);
            r_goal    <= FLOOR_W'(1);
            r_heading <= HEAD_STOP;
        end else begin
            r_pending <= n_pending;
            r_cabin   <= n_cabin;
            r_goal    <= n_goal;
            r_heading <= n_heading;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
        end
        r_event <= n_event;
    end

    assign o_event_res    = r_event;
    assign o_cabin_floor  = r_cabin;
    assign o_target_floor = r_goal;
    assign o_heading      = r_heading;

endmodule

`default_nettype wire

[rtl/ets_checker.sv]
// Port-level checker for the elevator target scheduler, with its bind.
`default_nettype none

`include "elevator_target_scheduler_assert.svh"

module ets_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          o_in_stall,
    input  wire logic                          o_out_valid,
    input  wire logic                          i_out_stall,
    input  wire logic [1:0]                    o_event_res,
    input  wire logic [ets_pkg::FLOOR_W-1:0]   o_cabin_floor,
    input  wire logic [ets_pkg::FLOOR_W-1:0]   o_target_floor,
    input  wire logic [1:0]                    o_heading
);
    import ets_pkg::*;

    logic in_beat;
    logic out_hold;

    assign in_beat  = i_in_valid && !o_in_stall;
    assign out_hold = o_out_valid && i_out_stall;

    `ETS_ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, out_hold, o_out_valid, "result beat dropped while stalled")
    `ETS_ASSERT_NEXT(a_out_payload_holds, i_clk, i_rst_n, out_hold, $stable(o_event_res) && $stable(o_cabin_floor) && $stable(o_target_floor) && $stable(o_heading), "stalled result beat changed")
    `ETS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_beat, o_in_stall, "input accepted on two cycles in a row")
    `ETS_ASSERT_SAME(a_floors_in_range, i_clk, i_rst_n, o_out_valid, (o_cabin_floor != '0) && (32'(o_cabin_floor) <= FLOORS) && (o_target_floor != '0) && (32'(o_target_floor) <= FLOORS) && (o_heading != 2'd3), "cabin, goal or heading out of range")

endmodule

bind elevator_target_scheduler ets_checker u_ets_checker (.*);

`default_nettype wire

[bench/ets_trip_checker.sv]
// Checker that predicts and compares the result beats of the elevator target scheduler.
`timescale 1ns / 100ps

module ets_trip_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [1:0]                    i_kind,
    input  logic [ets_pkg::FLOOR_W-1:0]   i_floor,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [1:0]                    i_event_res,
    input  logic [ets_pkg::FLOOR_W-1:0]   i_cabin_floor,
    input  logic [ets_pkg::FLOOR_W-1:0]   i_target_floor,
    input  logic [1:0]                    i_heading,
    output int                            o_fail_count,
    output int                            o_pending_count
);
    import ets_pkg::*;

    localparam logic [1:0] MODE_FREE = 2'd0;
    localparam logic [1:0] MODE_NEW  = 2'd1;
    localparam logic [1:0] MODE_BUSY = 2'd2;

    // Expected results wait in a small ring; the block never holds more
    // than two beats at once.
    localparam int RING_DEPTH = 16;

    typedef struct packed {
        logic [1:0]         ev;
        logic [FLOOR_W-1:0] cabin;
        logic [FLOOR_W-1:0] goal;
        logic [1:0]         head;
    } t_trip;

    logic [FLOORS-1:0]  pend_map;
    logic [FLOOR_W-1:0] cab_pos;
    logic [FLOOR_W-1:0] goal_pos;
    logic [1:0]         head_dir;
    logic [1:0]         run_mode;
    t_trip              exp_ring[RING_DEPTH];
    int                 wr_cnt;
    int                 rd_cnt;
    int                 errs;

    initial begin
        o_fail_count    = 0;
        o_pending_count = 0;
        errs            = 0;
        wr_cnt          = 0;
        rd_cnt          = 0;
    end

    // Nearest pending floor, walking first along the heading (down when
    // stopped), then the other way. Zero means nothing is pending.
    function automatic logic [FLOOR_W-1:0] nearest_call();
        int   fl;
        logic up;
        up = (head_dir == HEAD_UP);
        for (int pass = 0; pass < 2; pass++) begin
            fl = cab_pos;
            while (fl >= 1 && fl <= FLOORS) begin
                if (pend_map[fl-1]) begin
                    return FLOOR_W'(fl);
                end
                fl = up ? fl + 1 : fl - 1;
            end
            up = !up;
        end
        return '0;
    endfunction

    function automatic t_trip predict_trip(input logic [1:0] kind, input logic [FLOOR_W-1:0] fl);
        t_trip              t;
        logic [FLOOR_W-1:0] hit;
        t.ev = EV_NONE;
        if (kind == KIND_PRESS || kind == KIND_RESCAN) begin
            if (kind == KIND_PRESS && fl >= 1 && fl <= FLOORS) begin
                pend_map[fl-1] = 1'b1;
            end
            hit = nearest_call();
            if (hit != 0) begin
                goal_pos = hit;
                run_mode = MODE_NEW;
                head_dir = (hit > cab_pos) ? HEAD_UP : HEAD_DOWN;
                t.ev     = EV_NEW;
            end
        end else if (kind == KIND_TICK) begin
            run_mode = MODE_BUSY;
            if (goal_pos == cab_pos) begin
                pend_map[goal_pos-1] = 1'b0;
                t.ev = EV_STOP;
            end else begin
                if (head_dir == HEAD_UP && cab_pos < FLOORS) begin
                    cab_pos = cab_pos + 1'b1;
                end else if (head_dir == HEAD_DOWN && cab_pos > 1) begin
                    cab_pos = cab_pos - 1'b1;
                end
                t.ev = EV_MOVED;
            end
        end
        t.cabin = cab_pos;
        t.goal  = goal_pos;
        t.head  = head_dir;
        return t;
    endfunction

    always @(posedge i_clk) begin
        t_trip exp_t;
        if (!i_rst_n) begin
            pend_map = '0;
            cab_pos  = FLOOR_W'(1);
            goal_pos = FLOOR_W'(1);
            head_dir = HEAD_STOP;
            run_mode = MODE_FREE;
            wr_cnt   = 0;
            rd_cnt   = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (wr_cnt == rd_cnt) begin
                    $error("result beat with no expected result waiting");
                    errs++;
                end else begin
                    exp_t  = exp_ring[rd_cnt % RING_DEPTH];
                    rd_cnt = rd_cnt + 1;
                    if (i_event_res !== exp_t.ev) begin
                        $error("event_res: expected %0d, actual %0d", exp_t.ev, i_event_res);
                        errs++;
                    end
                    if (i_cabin_floor !== exp_t.cabin) begin
                        $error("cabin_floor: expected %0d, actual %0d",
                               exp_t.cabin, i_cabin_floor);
                        errs++;
                    end
                    if (i_target_floor !== exp_t.goal) begin
                        $error("target_floor: expected %0d, actual %0d",
                               exp_t.goal, i_target_floor);
                        errs++;
                    end
                    if (i_heading !== exp_t.head) begin
                        $error("heading: expected %0d, actual %0d", exp_t.head, i_heading);
                        errs++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (wr_cnt - rd_cnt >= RING_DEPTH) begin
                    $error("too many result beats outstanding");
                    errs++;
                end else begin
                    exp_ring[wr_cnt % RING_DEPTH] = predict_trip(i_kind, i_floor);
                    wr_cnt = wr_cnt + 1;
                end
            end
        end
        o_fail_count    <= errs;
        o_pending_count <= wr_cnt - rd_cnt;
    end

endmodule

[bench/tb_elevator_target_scheduler.sv]
// Testbench top for the elevator target scheduler: stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb_elevator_target_scheduler;

    import ets_pkg::*;

    // The fourth kind code is not in the package; the block must ignore it.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Random beats per stall phase, beats of the back-pressure step, and the length of the long receiver hold.
    localparam int PHASE_BEATS   = 400;
    localparam int SQUEEZE_BEATS = 30;
    localparam int HOLD_CYCLES   = 200;
    // Cycles without any accepted beat before the run is declared hung. The
    // long hold is the slowest stretch of a correct run; this is well above it.
    localparam int WATCHDOG_MAX  = 2000;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic [1:0]         i_kind         = KIND_RESCAN;
    logic [FLOOR_W-1:0] i_floor        = '0;
    logic               i_out_stall    = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [1:0]         o_event_res;
    logic [FLOOR_W-1:0] o_cabin_floor;
    logic [FLOOR_W-1:0] o_target_floor;
    logic [1:0]         o_heading;

    int fail_count;
    int pending_count;

    // Percentages of cycles in which the sender idles or the receiver stalls.
    int idle_pct  = 0;
    int stall_pct = 0;

    // Raised once by the stimulus to ask the receiver for its long hold.
    logic squeeze_req = 1'b0;

    // Bookkeeping of the long receiver hold.
    int   hold_left  = 0;
    logic hold_taken = 1'b0;

    int hung_cycles = 0;

    always #4 i_clk = ~i_clk;

    elevator_target_scheduler u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_floor        (i_floor),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_event_res    (o_event_res),
        .o_cabin_floor  (o_cabin_floor),
        .o_target_floor (o_target_floor),
        .o_heading      (o_heading)
    );

    ets_trip_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_floor         (i_floor),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_event_res     (o_event_res),
        .i_cabin_floor   (o_cabin_floor),
        .i_target_floor  (o_target_floor),
        .i_heading       (o_heading),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    // Receiver side. Normally it stalls at random with the current phase's
    // rate. When the stimulus asks for it, it holds the stall for a long
    // stretch, counted here, so the result path backs up into the input.
    always @(posedge i_clk) begin
        if (squeeze_req && !hold_taken) begin
            hold_taken  = 1'b1;
            hold_left   = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog: any accepted beat on either channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            hung_cycles <= 0;
        end else if (hung_cycles >= WATCHDOG_MAX) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            hung_cycles <= hung_cycles + 1;
        end
    end

    // Offers one beat, idling first at the phase's rate, and returns at the
    // edge where the block takes it. The payload stays put while stalled,
    // and a valid that stays high between beats is never dropped in between.
    task automatic send_beat(input logic [1:0] kind, input logic [FLOOR_W-1:0] fl);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_floor    <= fl;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    // Random beat, weighted toward presses and ticks so the cabin really
    // travels, picks up calls on the way and stops at its goals. A few beats
    // are rescans, out-of-range presses and the ignored kind, carrying any
    // floor code so every bit of the field toggles.
    task automatic send_random_beat();
        int                 roll;
        logic [1:0]         kind;
        logic [FLOOR_W-1:0] fl;
        roll = $urandom_range(99);
        if (roll < 5) begin
            kind = KIND_UNUSED;
            fl   = FLOOR_W'($urandom_range(31));
        end else if (roll < 15) begin
            kind = KIND_RESCAN;
            fl   = FLOOR_W'($urandom_range(31));
        end else if (roll < 50) begin
            kind = KIND_PRESS;
            if ($urandom_range(9) == 0) begin
                fl = FLOOR_W'($urandom_range(31));
            end else begin
                fl = FLOOR_W'($urandom_range(FLOORS, 1));
            end
        end else begin
            kind = KIND_TICK;
            fl   = '0;
        end
        send_beat(kind, fl);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats, with no idling on either side.
        // The ignored kind and a rescan with nothing pending both report
        // nothing; a tick right after reset finds the cabin at its goal.
        send_beat(KIND_UNUSED, 5'd31);
        send_beat(KIND_RESCAN, 5'd0);
        send_beat(KIND_TICK, 5'd0);
        // Presses of floor zero and of floors above the top mark nothing.
        send_beat(KIND_PRESS, 5'd0);
        send_beat(KIND_PRESS, 5'd17);
        send_beat(KIND_PRESS, 5'd31);
        // A call on the cabin's own floor makes it the goal with heading down,
        // and the next tick stops there and clears the call.
        send_beat(KIND_PRESS, 5'd1);
        send_beat(KIND_TICK, 5'd0);
        // A call on the top floor: the cabin travels the whole shaft up and
        // stops there.
        send_beat(KIND_PRESS, FLOOR_W'(FLOORS));
        repeat (FLOORS) send_beat(KIND_TICK, 5'd0);
        // The call is cleared, so a rescan finds nothing; its floor is ignored.
        send_beat(KIND_RESCAN, 5'd31);

        // Random beats in four stall phases: none, sender idling, receiver
        // stalling, then both at a lighter rate.
        idle_pct  = 0;
        stall_pct = 0;
        repeat (PHASE_BEATS) send_random_beat();
        idle_pct  = 57;
        repeat (PHASE_BEATS) send_random_beat();
        idle_pct  = 0;
        stall_pct = 57;
        repeat (PHASE_BEATS) send_random_beat();
        idle_pct  = 22;
        stall_pct = 22;
        repeat (PHASE_BEATS) send_random_beat();

        // Back-pressure: the receiver holds off for a long stretch while the
        // sender keeps offering beats back to back, so the block fills up and
        // stalls its input until the hold ends.
        idle_pct    = 0;
        stall_pct   = 0;
        squeeze_req = 1'b1;
        repeat (SQUEEZE_BEATS) send_random_beat();

        // Drain: wait for every expected result, then wait on so that a stray extra
        // result beat would still be caught. The count is registered and trails the
        // last accepted beat, so the wait begins after the next edge.
        stall_pct = 22;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/ets_pkg.sv
rtl/ets_ctrl.sv
rtl/ets_datapath.sv
rtl/elevator_target_scheduler.sv
rtl/ets_checker.sv
bench/ets_trip_checker.sv
bench/tb_elevator_target_scheduler.sv
